FILE: rtl/core/lcdnib_pkg.sv
// Package with the shared types, codes and write tables of the LCD nibble sequencer.
package lcdnib_pkg;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_CURSOR = 3'd2,
    CMD_CHAR   = 3'd3,
    CMD_RAW    = 3'd4
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_CMD_PULSE  = 1'b0,
    CFG_DATA_PULSE = 1'b1
  } cfg_reg_t;

  localparam int unsigned IdxW   = 4;
  localparam int unsigned InitN  = 11;
  localparam logic [7:0]  CmdPulseRst  = 8'd2;
  localparam logic [7:0]  DataPulseRst = 8'd5;
  localparam logic [9:0]  SettleWait   = 10'd1010;
  localparam logic [7:0]  Row1Base     = 8'h80;
  localparam logic [7:0]  Row2Base     = 8'hC0;

  typedef struct packed {
    logic [3:0] raw_nibble;
    logic [7:0] char_code;
    logic [5:0] col;
    logic [1:0] row;
    logic [2:0] command;
  } item_t;

  typedef struct packed {
    logic [9:0] wait_ms;
    logic [7:0] pulse_ms;
    logic       enable_pulse;
    logic [3:0] data_nibble;
    logic       reg_select;
  } write_t;

  function automatic logic [3:0] init_nib(input logic [IdxW-1:0] idx);
    logic [3:0] nib;
    unique case (idx)
      4'd1, 4'd2, 4'd3: nib = 4'h3;
      4'd4, 4'd5:       nib = 4'h2;
      4'd6:             nib = 4'h8;
      4'd8:             nib = 4'hC;
      4'd10:            nib = 4'h6;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  function automatic logic [9:0] init_wait(input logic [IdxW-1:0] idx);
    logic [9:0] w;
    unique case (idx)
      4'd0:    w = SettleWait;
      4'd1:    w = 10'd5;
      4'd2:    w = 10'd11;
      default: w = 10'd0;
    endcase
    return w;
  endfunction

  function automatic logic [IdxW-1:0] write_count(input item_t it);
    logic [IdxW-1:0] n;
    unique case (it.command)
      CMD_INIT:   n = IdxW'(InitN);
      CMD_CLEAR:  n = 4'd2;
      CMD_CURSOR: n = (it.row == 2'd1 || it.row == 2'd2) ? 4'd2 : 4'd0;
      CMD_CHAR:   n = 4'd2;
      CMD_RAW:    n = 4'd1;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/char_lcd_nibble_sequencer_core.sv
// Top level of the LCD nibble sequencer: request register, write generator, result register.
// A request's first write is loaded into the result register after the request register takes it.
// Throughput: one write per cycle unless m_axis_tready stalls the result; a request holds the request
// register until its last write is loaded (init has eleven writes; clear, character and a row 1 or 2
// cursor two; raw one; others none). The next request enters as the last write leaves.
// Reset: rst_n clears both valid flags and loads the pulse widths 2 ms and 5 ms.
module char_lcd_nibble_sequencer_core
  import lcdnib_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], row[4:3], col[10:5], char_code[18:11], raw_nibble[22:19], zero [23]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // reg_select[0], data_nibble[4:1], enable_pulse[5], pulse_ms[13:6], wait_ms[23:14]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic            hold_v_r, hold_v_nxt;
  item_t           item_r;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [7:0]      cmd_pulse_r, data_pulse_r;
  logic            out_v_r, out_v_nxt;
  write_t          out_r;
  logic            out_last_r;

  logic [IdxW-1:0] count;
  logic            is_last, out_load, hold_done, in_accept;
  logic [7:0]      addr;
  write_t          wr;

  assign count    = write_count(item_r);
  assign is_last  = (idx_r == count - 4'd1);
  assign out_load = hold_v_r && (count != '0) && (!out_v_r || m_axis_tready);
  assign hold_done = hold_v_r && ((count == '0) || (out_load && is_last));
  assign s_axis_tready = !hold_v_r || hold_done;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  assign addr = ((item_r.row == 2'd1) ? Row1Base : Row2Base) + {2'b00, item_r.col} + 8'hFF;

  always_comb begin
    wr.reg_select   = 1'b0;
    wr.data_nibble  = 4'h0;
    wr.enable_pulse = 1'b1;
    wr.pulse_ms     = cmd_pulse_r;
    wr.wait_ms      = 10'd0;
    unique case (item_r.command)
      CMD_INIT: begin
        wr.data_nibble = init_nib(idx_r);
        wr.wait_ms     = init_wait(idx_r);
        if (idx_r == '0) begin
          wr.enable_pulse = 1'b0;
          wr.pulse_ms     = 8'd0;
        end
      end
      CMD_CLEAR:  wr.data_nibble = {3'b000, idx_r[0]};
      CMD_CURSOR: wr.data_nibble = idx_r[0] ? addr[3:0] : addr[7:4];
      CMD_CHAR: begin
        wr.reg_select  = 1'b1;
        wr.pulse_ms    = data_pulse_r;
        wr.data_nibble = idx_r[0] ? item_r.char_code[3:0] : item_r.char_code[7:4];
      end
      CMD_RAW:    wr.data_nibble = item_r.raw_nibble;
      default:    wr.data_nibble = 4'h0;
    endcase
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    idx_nxt    = idx_r;
    if (out_load) begin
      idx_nxt = idx_r + 4'd1;
    end
    if (hold_done) begin
      hold_v_nxt = 1'b0;
    end
    if (in_accept) begin
      hold_v_nxt = 1'b1;
      idx_nxt    = '0;
    end
    out_v_nxt = out_load || (out_v_r && !m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r     <= 1'b0;
      idx_r        <= '0;
      out_v_r      <= 1'b0;
      cmd_pulse_r  <= CmdPulseRst;
      data_pulse_r <= DataPulseRst;
    end else begin
      hold_v_r <= hold_v_nxt;
      idx_r    <= idx_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_valid && cfg_index[1] == 1'b0) begin
        if (cfg_index[0] == CFG_CMD_PULSE) begin
          cmd_pulse_r <= cfg_data;
        end else begin
          data_pulse_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= item_t'(s_axis_tdata[22:0]);
    end
    if (out_load) begin
      out_r      <= wr;
      out_last_r <= is_last;
    end
  end

  assign m_axis_tvalid = out_v_r;
  assign m_axis_tdata  = out_r;
  assign m_axis_tlast  = out_last_r;

endmodule

FILE: rtl/core/lcdnib_checker.sv
// Port checker for the LCD nibble sequencer, bound to the top level.
module lcdnib_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic out_xfer;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_settle_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !m_axis_tdata[5] |-> m_axis_tdata[23:14] == 10'd1010
      && !m_axis_tdata[0] && !m_axis_tlast && m_axis_tdata[13:6] == 8'd0)
    else $error("settle write malformed");

  a_settle_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !m_axis_tdata[5] |=> m_axis_tvalid)
    else $error("init run broken after settle write");

  a_data_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && m_axis_tdata[0] |-> m_axis_tdata[5] && m_axis_tdata[23:14] == 10'd0)
    else $error("character write malformed");

endmodule

bind char_lcd_nibble_sequencer_core lcdnib_checker u_lcdnib_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_char_lcd_nibble_sequencer_core.sv
// Self-checking testbench for the character LCD nibble sequencer core.
module tb_char_lcd_nibble_sequencer_core
  import lcdnib_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNDEF_LO   = 3'd5;
  localparam logic [2:0] CMD_UNDEF_MID  = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI   = 3'd7;
  localparam logic [1:0] CFG_IDX_SPARE0 = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE1 = 2'd3;
  localparam int         DRAIN_CYCLES   = 4;
  localparam int         FINAL_LIMIT    = 5000;

  typedef struct {
    write_t w;
    bit     last;
  } lcd_write_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  lcd_write_exp_t writes_due[$];
  logic [7:0]     cmd_pulse_ms;
  logic [7:0]     data_pulse_ms;
  int             n_errors = 0;
  int             burst_left = 0;
  int             tx_gap_max = 0;
  int             rx_stall_pct = 0;
  int             rx_hold_cycles = 0;

  logic [3:0] init_nibbles[11] = '{4'h0, 4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0, 4'hC,
                                   4'h0, 4'h6};
  logic [9:0] init_waits[11] = '{10'd1010, 10'd5, 10'd11, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
                                 10'd0, 10'd0, 10'd0};

  char_lcd_nibble_sequencer_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void push_write(logic rs, logic [3:0] nib, logic en, logic [7:0] pulse,
                                     logic [9:0] wait_ms);
    lcd_write_exp_t e;
    e.w.reg_select   = rs;
    e.w.data_nibble  = nib;
    e.w.enable_pulse = en;
    e.w.pulse_ms     = pulse;
    e.w.wait_ms      = wait_ms;
    e.last           = 1'b0;
    writes_due.push_back(e);
  endfunction

  function automatic void expand_request(item_t it);
    int         n_prev;
    logic [7:0] addr;
    n_prev = writes_due.size();
    case (it.command)
      CMD_INIT: begin
        push_write(1'b0, init_nibbles[0], 1'b0, 8'd0, init_waits[0]);
        for (int i = 1; i < 11; i++) begin
          push_write(1'b0, init_nibbles[i], 1'b1, cmd_pulse_ms, init_waits[i]);
        end
      end
      CMD_CLEAR: begin
        push_write(1'b0, 4'h0, 1'b1, cmd_pulse_ms, 10'd0);
        push_write(1'b0, 4'h1, 1'b1, cmd_pulse_ms, 10'd0);
      end
      CMD_CURSOR: begin
        if (it.row == 2'd1 || it.row == 2'd2) begin
          addr = ((it.row == 2'd1) ? 8'h80 : 8'hC0) + {2'b00, it.col} - 8'd1;
          push_write(1'b0, addr[7:4], 1'b1, cmd_pulse_ms, 10'd0);
          push_write(1'b0, addr[3:0], 1'b1, cmd_pulse_ms, 10'd0);
        end
      end
      CMD_CHAR: begin
        push_write(1'b1, it.char_code[7:4], 1'b1, data_pulse_ms, 10'd0);
        push_write(1'b1, it.char_code[3:0], 1'b1, data_pulse_ms, 10'd0);
      end
      CMD_RAW: push_write(1'b0, it.raw_nibble, 1'b1, cmd_pulse_ms, 10'd0);
      default: ;
    endcase
    if (writes_due.size() > n_prev) begin
      writes_due[writes_due.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    write_t         got;
    lcd_write_exp_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (writes_due.size() == 0) begin
        $display("%0t ns: unexpected write, expected none, actual %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = writes_due.pop_front();
        check_field("reg_select", want.w.reg_select, got.reg_select);
        check_field("data_nibble", want.w.data_nibble, got.data_nibble);
        check_field("enable_pulse", want.w.enable_pulse, got.enable_pulse);
        check_field("pulse_ms", want.w.pulse_ms, got.pulse_ms);
        check_field("wait_ms", want.w.wait_ms, got.wait_ms);
        check_field("last_write", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_request(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it};
    do @(posedge clk); while (!s_axis_tready);
    expand_request(it);
  endtask

  task automatic wait_idle(int limit);
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (writes_due.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == 2'(CFG_CMD_PULSE)) cmd_pulse_ms = val;
    else if (idx == 2'(CFG_DATA_PULSE)) data_pulse_ms = val;
    @(posedge clk);
  endtask

  function automatic item_t make_item(logic [2:0] command, logic [1:0] row, logic [5:0] col,
                                      logic [7:0] char_code, logic [3:0] raw_nibble);
    item_t it;
    it.command    = command;
    it.row        = row;
    it.col        = col;
    it.char_code  = char_code;
    it.raw_nibble = raw_nibble;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it   = make_item(CMD_INIT, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    pick = $urandom_range(0, 99);
    if (pick < 8) it.command = CMD_INIT;
    else if (pick < 23) it.command = CMD_CLEAR;
    else if (pick < 50) it.command = CMD_CURSOR;
    else if (pick < 75) it.command = CMD_CHAR;
    else if (pick < 92) it.command = CMD_RAW;
    else it.command = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
    return it;
  endfunction

  task automatic test_directed();
    tx_gap_max   = 0;
    rx_stall_pct = 0;
    send_request(make_item(CMD_INIT, 2'd0, 6'd0, 8'h00, 4'h0));
    send_request(make_item(CMD_CLEAR, 2'd3, 6'd63, 8'hFF, 4'hF));
    send_request(make_item(CMD_CURSOR, 2'd1, 6'd1, 8'h00, 4'h0));
    send_request(make_item(CMD_CURSOR, 2'd1, 6'd0, 8'h00, 4'h0));
    send_request(make_item(CMD_CURSOR, 2'd2, 6'd63, 8'hFF, 4'hF));
    send_request(make_item(CMD_CURSOR, 2'd2, 6'd0, 8'h00, 4'h0));
    send_request(make_item(CMD_CURSOR, 2'd0, 6'd5, 8'h00, 4'h0));
    send_request(make_item(CMD_CURSOR, 2'd3, 6'd5, 8'h00, 4'h0));
    send_request(make_item(CMD_CHAR, 2'd0, 6'd0, 8'h00, 4'h0));
    send_request(make_item(CMD_CHAR, 2'd3, 6'd63, 8'hFF, 4'hF));
    send_request(make_item(CMD_CHAR, 2'd1, 6'd21, 8'hA5, 4'h5));
    send_request(make_item(CMD_RAW, 2'd0, 6'd0, 8'h00, 4'h0));
    send_request(make_item(CMD_RAW, 2'd3, 6'd63, 8'hFF, 4'hF));
    send_request(make_item(CMD_UNDEF_LO, 2'd1, 6'd1, 8'h41, 4'h3));
    send_request(make_item(CMD_UNDEF_MID, 2'd2, 6'd2, 8'h42, 4'h4));
    send_request(make_item(CMD_UNDEF_HI, 2'd3, 6'd63, 8'hFF, 4'hF));
    send_request(make_item(CMD_RAW, 2'd1, 6'd9, 8'h7E, 4'hA));
    wait_idle(FINAL_LIMIT);
  endtask

  task automatic test_config_extremes();
    logic [7:0] settings[3][2] = '{'{8'd0, 8'd255}, '{8'd255, 8'd0}, '{8'd1, 8'd128}};
    tx_gap_max   = 3;
    rx_stall_pct = 30;
    for (int s = 0; s < 3; s++) begin
      write_reg(2'(CFG_CMD_PULSE), settings[s][0]);
      write_reg(2'(CFG_DATA_PULSE), settings[s][1]);
      write_reg(CFG_IDX_SPARE0, 8'($urandom_range(0, 255)));
      write_reg(CFG_IDX_SPARE1, 8'($urandom_range(0, 255)));
      send_request(make_item(CMD_INIT, 2'd0, 6'd0, 8'h00, 4'h0));
      for (int i = 0; i < 6; i++) send_request(random_item());
      wait_idle(FINAL_LIMIT);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(2'(CFG_CMD_PULSE), 8'($urandom_range(0, 255)));
      write_reg(2'(CFG_DATA_PULSE), 8'($urandom_range(0, 255)));
      tx_gap_max   = (phase == 0) ? 0 : 2 * phase + 1;
      rx_stall_pct = (phase == 0) ? 0 : 20 * phase;
      for (int i = 0; i < 90; i++) send_request(random_item());
      wait_idle(FINAL_LIMIT);
    end
  endtask

  task automatic test_output_holdoff();
    tx_gap_max     = 0;
    rx_stall_pct   = 10;
    rx_hold_cycles = 300;
    for (int i = 0; i < 30; i++) send_request(random_item());
    wait_idle(FINAL_LIMIT);
  endtask

  initial begin
    cmd_pulse_ms  = CmdPulseRst;
    data_pulse_ms = DataPulseRst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_traffic();
    test_output_holdoff();
    wait_idle(FINAL_LIMIT);
    if (writes_due.size() != 0) begin
      $display("%0t ns: writes still due at end, expected 0, actual %0d", $time,
               writes_due.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lcdnib_pkg.sv
rtl/core/char_lcd_nibble_sequencer_core.sv
rtl/core/lcdnib_checker.sv
tb/tb_char_lcd_nibble_sequencer_core.sv
